// ----- rtl/ovle_pkg.sv -----
// package for the ordered value list engine: sizes, codes and state encoding
package ovle_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 32;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AFTER = 3'd2,
    REQ_DELETE    = 3'd3,
    REQ_READ      = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_type_e;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_MISS  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_ELEM  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ,
    S_RESP
  } state_e;

endpackage

// ----- rtl/ovle_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module ovle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/ordered_value_list_engine.sv -----
// top level of the ordered value list engine
// Holds up to 16 signed 32-bit values in a ram with registered read and serves one
// request at a time; the input is ready again in the cycle after the final result of
// the previous request is taken. Insert at the back, clear, unused types and requests
// refused as full, empty or missing on an empty list go straight to the response state.
// Searches check one entry per cycle through the single read port. Inserts move entries
// up one place, from the back, reading each entry and then writing it one higher. A
// read-out sends the elements in order, each read before it is sent, and waits while
// the output is not taken. Inserts into a full list answer full; every request's final
// result carries last.
module ordered_value_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // req_type[2:0], new_value[34:3], match_value[66:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status[2:0], elem_value[34:3], elem_count[39:35]
  output logic        m_axis_tlast   // last
);
  import ovle_pkg::*;

  state_e state_q, state_d;
  logic [2:0]      type_q, type_d;
  logic [ValW-1:0] nv_q, nv_d, key_q, key_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d, pos_q, pos_d;
  logic            rvld_q, rvld_d;
  logic [ValW-1:0] hold_q, hold_d;
  logic            ov_q, ov_d;
  logic [2:0]      ost_q, ost_d;
  logic [ValW-1:0] oval_q, oval_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;
  logic            olast_q, olast_d;

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [ValW-1:0] wdata, rdata;

  ovle_ram #(.Width(ValW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic in_acc, out_free;
  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    type_d = type_q; nv_d = nv_q; key_d = key_q; cnt_d = cnt_q;
    idx_d = idx_q; pos_d = pos_q; rvld_d = 1'b0; hold_d = hold_q;
    ov_d = ov_q && !m_axis_tready;
    ost_d = ost_q; oval_d = oval_q; ocnt_d = ocnt_q; olast_d = olast_q;
    we = 1'b0; waddr = '0; wdata = nv_q; raddr = idx_q[AddrW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          type_d = s_axis_tdata[2:0];
          nv_d   = s_axis_tdata[34:3];
          key_d  = s_axis_tdata[66:35];
          idx_d  = '0;
          ost_d  = ST_DONE;
          state_d = S_RESP;
          unique case (s_axis_tdata[2:0])
            REQ_INS_FRONT, REQ_INS_BACK: begin
              if (cnt_q >= CntW'(Capacity)) ost_d = ST_FULL;
              else if (s_axis_tdata[2:0] == REQ_INS_BACK) begin
                we = 1'b1; waddr = cnt_q[AddrW-1:0]; wdata = s_axis_tdata[34:3];
                cnt_d = cnt_q + 1'b1;
              end else begin
                pos_d = '0; idx_d = cnt_q;
                state_d = S_SHIFT_UP;
              end
            end
            REQ_INS_AFTER: begin
              if (cnt_q >= CntW'(Capacity)) ost_d = ST_FULL;
              else if (cnt_q == '0) ost_d = ST_MISS;
              else state_d = S_SEARCH;
            end
            REQ_DELETE: begin
              if (cnt_q == '0) ost_d = ST_EMPTY;
              else state_d = S_SEARCH;
            end
            REQ_READ: begin
              if (cnt_q == '0) ost_d = ST_EMPTY;
              else begin state_d = S_READ; rvld_d = 1'b1; end
              idx_d = (cnt_q == '0) ? '0 : CntW'(1);
              raddr = '0;
            end
            REQ_CLEAR: cnt_d = '0;
            default: ;
          endcase
          if (s_axis_tdata[2:0] == REQ_INS_AFTER || s_axis_tdata[2:0] == REQ_DELETE) begin
            raddr = '0; rvld_d = 1'b1; idx_d = CntW'(1);
          end
        end
      end
      S_SEARCH: begin
        // idx_q is one ahead of the entry in rdata
        raddr = idx_q[AddrW-1:0];
        if (rvld_q && rdata == key_q) begin
          if (type_q == REQ_INS_AFTER) begin
            pos_d = idx_q; idx_d = cnt_q; state_d = S_SHIFT_UP;
          end else begin
            pos_d = idx_q - 1'b1; state_d = S_SHIFT_DN;
            raddr = idx_q[AddrW-1:0]; rvld_d = (idx_q < cnt_q);
            idx_d = idx_q;
            if (idx_q >= cnt_q) begin
              cnt_d = cnt_q - 1'b1; state_d = S_RESP;
            end
          end
        end else if (idx_q >= cnt_q) begin
          ost_d = ST_MISS; state_d = S_RESP;
        end else begin
          rvld_d = 1'b1; idx_d = idx_q + 1'b1;
        end
      end
      S_SHIFT_UP: begin
        // entries pos..cnt-1 move up by one, from the back; idx_q is destination
        if (idx_q == pos_q) begin
          we = 1'b1; waddr = pos_q[AddrW-1:0]; wdata = nv_q;
          cnt_d = cnt_q + 1'b1; state_d = S_RESP;
        end else if (!rvld_q) begin
          raddr = AddrW'(idx_q - 1'b1); rvld_d = 1'b1;
        end else begin
          we = 1'b1; waddr = idx_q[AddrW-1:0]; wdata = rdata;
          idx_d = idx_q - 1'b1;
        end
      end
      S_SHIFT_DN: begin
        // rdata holds entry idx_q, written to pos_q
        if (rvld_q) begin
          we = 1'b1; waddr = pos_q[AddrW-1:0]; wdata = rdata;
          pos_d = pos_q + 1'b1;
          if (idx_q + 1'b1 >= cnt_q) begin
            cnt_d = cnt_q - 1'b1; state_d = S_RESP;
          end else begin
            idx_d = idx_q + 1'b1; raddr = AddrW'(idx_q + 1'b1); rvld_d = 1'b1;
          end
        end
      end
      S_READ: begin
        if (rvld_q || !out_free) hold_d = rvld_q ? rdata : hold_q;
        if (out_free && !rvld_q) begin
          ov_d = 1'b1; ost_d = ST_ELEM; oval_d = hold_q; ocnt_d = cnt_q;
          olast_d = (idx_q >= cnt_q);
          if (idx_q >= cnt_q) state_d = S_IDLE;
          else begin raddr = idx_q[AddrW-1:0]; rvld_d = 1'b1; idx_d = idx_q + 1'b1; end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d = 1'b1; oval_d = '0; ocnt_d = cnt_q; olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; ov_q <= 1'b0; rvld_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ov_q <= ov_d; rvld_q <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d; nv_q <= nv_d; key_q <= key_d; idx_q <= idx_d; pos_q <= pos_d;
    hold_q <= hold_d; ost_q <= ost_d; oval_q <= oval_d; ocnt_q <= ocnt_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {ocnt_q, oval_q, ost_q};
  assign m_axis_tlast  = olast_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity)) else $error("count above capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready) else $error("accept while busy");

endmodule
